FILE: sv/ces_pkg.sv
// Package: shared types and constants of the streaming edge detector.
`default_nettype none
package ces_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned TAN_LO_Q16    = 27146;
  localparam int unsigned TAN_HI_Q16    = 158218;
  localparam int unsigned MAG_BITS      = 21;
  localparam int unsigned FIFO_DEPTH    = 8;
  localparam int unsigned PIPE_DEPTH    = 5;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;
  localparam logic [7:0]  THRESH_RST = 8'd50;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2,
    REG_NONE   = 2'd3
  } ces_reg_e;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } ces_dir_e;

  // Per-item position flags, worked out at entry and carried down the pipe.
  typedef struct packed {
    logic blur_zero;
    logic grad_zero;
    logic mask_zero;
    logic emit;
    logic last;
  } ces_tag_t;

  // Products of one gradient, registered before magnitude and angle tests.
  typedef struct packed {
    logic [19:0] ax2;
    logic [19:0] ay2;
    logic [9:0]  ay;
    logic [24:0] p_lo;
    logic [27:0] p_hi;
    logic        gx_pos;
    logic        zero;
  } ces_prod_t;

  typedef struct packed {
    ces_dir_e             dir;
    logic [MAG_BITS-1:0]  mag;
  } ces_entry_t;

endpackage
`default_nettype wire

FILE: sv/ces_if.sv
// Interfaces: pixel input channel and mask output channel.
`default_nettype none
interface ces_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] pixel;
  modport source (output valid, action, pixel, input ready);
  modport sink   (input valid, action, pixel, output ready);
endinterface

interface ces_out_if;
  logic valid;
  logic ready;
  logic mask_on;
  logic last_of_frame;
  modport source (output valid, mask_on, last_of_frame, input ready);
  modport sink   (input valid, mask_on, last_of_frame, output ready);
endinterface
`default_nettype wire

FILE: sv/ces_blur.sv
// Raw line memory and 3x3 binomial blur stage.
`default_nettype none
module ces_blur #(
  parameter int unsigned MAX_WIDTH = ces_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic [7:0]        pixel_i,
  input  logic [AW-1:0]     raw_col_i,
  input  logic [AW-1:0]     blur_col_i,
  input  logic [AW-1:0]     grad_col_i,
  input  ces_pkg::ces_tag_t tag_i,
  output logic              valid_o,
  output logic [7:0]        blur_o,
  output logic [AW-1:0]     blur_col_o,
  output logic [AW-1:0]     grad_col_o,
  output ces_pkg::ces_tag_t tag_o
);
  import ces_pkg::*;

  // Each word holds the two previous rows at one column: {row-1, row-2}.
  logic [15:0]   raw_mem [MAX_WIDTH];
  logic [15:0]   rd_q;
  logic          v_q;
  logic [7:0]    pix_q;
  logic [AW-1:0] col_q, bcol_q, gcol_q;
  ces_tag_t      tag_q;
  logic [23:0]   wa_q, wb_q;
  logic [23:0]   wn;
  logic [11:0]   sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= tick_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      rd_q   <= raw_mem[raw_col_i];
      pix_q  <= pixel_i;
      col_q  <= raw_col_i;
      bcol_q <= blur_col_i;
      gcol_q <= grad_col_i;
      tag_q  <= tag_i;
    end
    if (v_q) begin
      raw_mem[col_q] <= {pix_q, rd_q[15:8]};
      wa_q <= wb_q;
      wb_q <= wn;
    end
  end

  // Column as {top, mid, bottom}.
  assign wn = {rd_q[7:0], rd_q[15:8], pix_q};

  assign sum = 12'(wa_q[23:16]) + {3'b0, wb_q[23:16], 1'b0} + 12'(wn[23:16])
             + {3'b0, wa_q[15:8], 1'b0} + {2'b0, wb_q[15:8], 2'b0}
             + {3'b0, wn[15:8], 1'b0}
             + 12'(wa_q[7:0]) + {3'b0, wb_q[7:0], 1'b0} + 12'(wn[7:0]);

  assign valid_o    = v_q;
  assign blur_o     = tag_q.blur_zero ? 8'd0 : sum[11:4];
  assign blur_col_o = bcol_q;
  assign grad_col_o = gcol_q;
  assign tag_o      = tag_q;

endmodule
`default_nettype wire

FILE: sv/ces_grad.sv
// Blur line memory, Sobel gradient and gradient products.
`default_nettype none
module ces_grad #(
  parameter int unsigned MAX_WIDTH = ces_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [7:0]         blur_i,
  input  logic [AW-1:0]      blur_col_i,
  input  logic [AW-1:0]      grad_col_i,
  input  ces_pkg::ces_tag_t  tag_i,
  output logic               valid_o,
  output ces_pkg::ces_prod_t prod_o,
  output logic [AW-1:0]      grad_col_o,
  output ces_pkg::ces_tag_t  tag_o
);
  import ces_pkg::*;

  logic [15:0]        blur_mem [MAX_WIDTH];
  logic [15:0]        rd_q;
  logic               v2_q, v3_q;
  logic [7:0]         b_q;
  logic [AW-1:0]      bcol_q, gcol2_q, gcol3_q;
  ces_tag_t           tag2_q, tag3_q;
  logic [23:0]        wa_q, wb_q;
  logic [23:0]        wn;
  logic signed [11:0] gx, gy, gx_q, gy_q;
  logic [9:0]         ax, ay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rd_q    <= blur_mem[blur_col_i];
      b_q     <= blur_i;
      bcol_q  <= blur_col_i;
      gcol2_q <= grad_col_i;
      tag2_q  <= tag_i;
    end
    if (v2_q) begin
      blur_mem[bcol_q] <= {b_q, rd_q[15:8]};
      wa_q    <= wb_q;
      wb_q    <= wn;
      gx_q    <= gx;
      gy_q    <= gy;
      gcol3_q <= gcol2_q;
      tag3_q  <= tag2_q;
    end
  end

  assign wn = {rd_q[7:0], rd_q[15:8], b_q};

  assign gx = (12'(wn[23:16]) - 12'(wa_q[23:16]))
            + ((12'(wn[15:8]) - 12'(wa_q[15:8])) <<< 1)
            + (12'(wn[7:0]) - 12'(wa_q[7:0]));
  assign gy = (12'(wa_q[7:0]) + {3'b0, wb_q[7:0], 1'b0} + 12'(wn[7:0]))
            - (12'(wa_q[23:16]) + {3'b0, wb_q[23:16], 1'b0} + 12'(wn[23:16]));

  assign ax = gx_q[11] ? 10'(-gx_q) : 10'(gx_q);
  assign ay = gy_q[11] ? 10'(-gy_q) : 10'(gy_q);

  always_comb begin
    prod_o.ax2    = {10'b0, ax} * {10'b0, ax};
    prod_o.ay2    = {10'b0, ay} * {10'b0, ay};
    prod_o.ay     = ay;
    prod_o.p_lo   = {15'b0, ax} * 25'(TAN_LO_Q16);
    prod_o.p_hi   = {18'b0, ax} * 28'(TAN_HI_Q16);
    // Sign of gx after folding the vector into the upper half plane.
    prod_o.gx_pos = gy_q[11] ? gx_q[11] : (!gx_q[11] && gx_q != 12'sd0);
    prod_o.zero   = (gx_q == 12'sd0) && (gy_q == 12'sd0);
  end

  assign valid_o    = v3_q;
  assign grad_col_o = gcol3_q;
  assign tag_o      = tag3_q;

endmodule
`default_nettype wire

FILE: sv/ces_nms.sv
// Gradient line memory, direction quantiser and non-maximum suppression.
`default_nettype none
module ces_nms #(
  parameter int unsigned MAX_WIDTH = ces_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ces_pkg::ces_prod_t prod_i,
  input  logic [AW-1:0]      grad_col_i,
  input  ces_pkg::ces_tag_t  tag_i,
  input  logic [7:0]         thresh_i,
  output logic               valid_o,
  output logic               mask_o,
  output logic               last_o
);
  import ces_pkg::*;

  localparam int unsigned EW = $bits(ces_entry_t);

  logic [2*EW-1:0]     grad_mem [MAX_WIDTH];
  logic [2*EW-1:0]     rd_q;
  logic                v4_q, v5_q;
  ces_prod_t           prod_q;
  logic [AW-1:0]       col4_q, col5_q;
  ces_tag_t            tag4_q, tag5_q;
  ces_entry_t          ent, ent_q;
  ces_entry_t          a_t_q, a_m_q, a_b_q, b_t_q, b_m_q, b_b_q;
  ces_entry_t          n_t, n_m;
  logic [MAG_BITS-1:0] n1, n2;
  logic [27:0]         gyq;
  logic [15:0]         t2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_comb begin
    gyq     = {2'b0, prod_q.ay, 16'b0};
    ent.mag = MAG_BITS'(prod_q.ax2) + MAG_BITS'(prod_q.ay2);
    if (prod_q.zero || gyq < {3'b0, prod_q.p_lo}) begin
      ent.dir = DIR_0;
    end else if (gyq < prod_q.p_hi) begin
      ent.dir = prod_q.gx_pos ? DIR_45 : DIR_135;
    end else begin
      ent.dir = DIR_90;
    end
    if (tag4_q.grad_zero) begin
      ent = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= prod_i;
      col4_q <= grad_col_i;
      tag4_q <= tag_i;
    end
    if (v4_q) begin
      rd_q   <= grad_mem[col4_q];
      ent_q  <= ent;
      col5_q <= col4_q;
      tag5_q <= tag4_q;
    end
    if (v5_q) begin
      grad_mem[col5_q] <= {ent_q, rd_q[2*EW-1:EW]};
      a_t_q <= b_t_q;
      a_m_q <= b_m_q;
      a_b_q <= b_b_q;
      b_t_q <= n_t;
      b_m_q <= n_m;
      b_b_q <= ent_q;
    end
  end

  assign n_t = rd_q[EW-1:0];
  assign n_m = rd_q[2*EW-1:EW];
  assign t2  = {8'b0, thresh_i} * {8'b0, thresh_i};

  // Centre is b_m_q; pick the two neighbours along its direction.
  always_comb begin
    case (b_m_q.dir)
      DIR_0:   begin n1 = a_m_q.mag; n2 = n_m.mag;   end
      DIR_45:  begin n1 = n_t.mag;   n2 = a_b_q.mag; end
      DIR_90:  begin n1 = b_t_q.mag; n2 = b_b_q.mag; end
      DIR_135: begin n1 = a_t_q.mag; n2 = ent_q.mag; end
      default: begin n1 = '0;        n2 = '0;        end
    endcase
  end

  assign valid_o = v5_q && tag5_q.emit;
  assign mask_o  = !tag5_q.mask_zero && (b_m_q.mag >= MAG_BITS'(t2))
                 && (b_m_q.mag >= n1) && (b_m_q.mag >= n2);
  assign last_o  = tag5_q.last;

endmodule
`default_nettype wire

FILE: sv/canny_edge_stream_top.sv
// Top level of the streaming edge detector: position control, pipeline and output queue.
`default_nettype none
// Streaming Canny-style edge mask. Gray pixels enter one per item in raster
// order; every accepted pixel (and every flush item after the last pixel of a
// frame) is one tick of the pipeline, which takes one item per clock, so the
// sustained rate is one item per cycle while the sink keeps up. The mask bit
// of raster pixel q leaves on the tick of input index q + 3*(W+1), since blur,
// gradient and suppression each need one row and one pixel of look-ahead;
// send W+1 flush items per stage (3*(W+1) in all) to drain a frame. The figure
// is set by the three line memories (raw, blur, gradient), each read once and
// written once per tick at a column that another tick touches only W ticks
// later, so no forwarding is needed. An eight-item output queue absorbs sink
// stalls; input ready drops while free slots do not exceed the pipeline depth.
// Flush items during a frame are taken and dropped. Register writes abort the
// frame and must only be issued while the block is idle.
module canny_edge_stream_top #(
  parameter int unsigned MAX_WIDTH = ces_pkg::MAX_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ces_in_if.sink         in_i,
  ces_out_if.source      out_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);
  import ces_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic [11:0] width_q;
  logic [15:0] height_q;
  logic [7:0]  thresh_q;
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;

  logic [16:0]   row_q, row_d;
  logic [AW-1:0] col_q, col_d;

  logic        accept, tick;
  logic [WW:0] xk   [1:3];
  logic signed [17:0] yk [1:3];
  logic signed [17:0] hm1;
  logic [WW:0] wm1;
  ces_tag_t    tag0;

  // Clamp geometry: width into [3, MAX_WIDTH], height to at least 3.
  always_comb begin
    if (width_q < 12'd3) begin
      w_eff = WW'(3);
    end else if ({2'b0, width_q} > 14'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q < 16'd3) ? 16'd3 : height_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thresh_q <= THRESH_RST;
    end else if (cfg_we_i) begin
      case (ces_reg_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_data_i[11:0];
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_THRESH: thresh_q <= cfg_data_i[7:0];
        default:    ;
      endcase
    end
  end

  // Positions of the blur, gradient and mask centres for this tick: one row
  // and one pixel back per stage, borrowing a row at the left edge.
  always_comb begin
    for (int k = 1; k <= 3; k++) begin
      if ((WW+1)'(col_q) >= (WW+1)'(k)) begin
        xk[k] = (WW+1)'(col_q) - (WW+1)'(k);
        yk[k] = $signed({1'b0, row_q}) - 18'(k);
      end else begin
        xk[k] = (WW+1)'(col_q) + (WW+1)'(w_eff) - (WW+1)'(k);
        yk[k] = $signed({1'b0, row_q}) - 18'(k) - 18'sd1;
      end
    end
  end

  assign hm1 = $signed({2'b0, h_eff}) - 18'sd1;
  assign wm1 = (WW+1)'(w_eff) - (WW+1)'(1);

  always_comb begin
    tag0.blur_zero = (yk[1] == 18'sd0) || (yk[1] == hm1)
                   || (xk[1] == '0) || (xk[1] == wm1);
    tag0.grad_zero = (yk[2] == 18'sd0) || (yk[2] == hm1)
                   || (xk[2] == '0) || (xk[2] == wm1);
    tag0.mask_zero = (yk[3] == 18'sd0) || (yk[3] == hm1)
                   || (xk[3] == '0) || (xk[3] == wm1);
    tag0.emit      = !yk[3][17] && (yk[3] <= hm1);
    tag0.last      = tag0.emit && (yk[3] == hm1) && (xk[3] == wm1);
  end

  // Drop a flush item while the frame is still arriving; everything else ticks.
  assign accept = in_i.valid && in_i.ready;
  assign tick   = accept && !(({1'b0, h_eff} > row_q) && in_i.action);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (tick) begin
      if (tag0.last) begin
        row_d = '0;
        col_d = '0;
      end else if ((WW+1)'(col_q) == wm1) begin
        col_d = '0;
        row_d = row_q + 17'd1;
      end else begin
        col_d = col_q + AW'(1);
      end
    end
    if (cfg_we_i && ces_reg_e'(cfg_idx_i) != REG_NONE) begin
      row_d = '0;
      col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Pipeline.
  logic          s1_v, s3_v, s5_v;
  logic [7:0]    s1_blur;
  logic [AW-1:0] s1_bcol, s1_gcol, s3_gcol;
  ces_tag_t      s1_tag, s3_tag;
  ces_prod_t     s3_prod;
  logic          s5_mask, s5_last;

  ces_blur #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_blur (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .pixel_i    (in_i.pixel),
    .raw_col_i  (col_q),
    .blur_col_i (AW'(xk[1])),
    .grad_col_i (AW'(xk[2])),
    .tag_i      (tag0),
    .valid_o    (s1_v),
    .blur_o     (s1_blur),
    .blur_col_o (s1_bcol),
    .grad_col_o (s1_gcol),
    .tag_o      (s1_tag)
  );

  ces_grad #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_grad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_v),
    .blur_i     (s1_blur),
    .blur_col_i (s1_bcol),
    .grad_col_i (s1_gcol),
    .tag_i      (s1_tag),
    .valid_o    (s3_v),
    .prod_o     (s3_prod),
    .grad_col_o (s3_gcol),
    .tag_o      (s3_tag)
  );

  ces_nms #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_nms (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s3_v),
    .prod_i     (s3_prod),
    .grad_col_i (s3_gcol),
    .tag_i      (s3_tag),
    .thresh_i   (thresh_q),
    .valid_o    (s5_v),
    .mask_o     (s5_mask),
    .last_o     (s5_last)
  );

  // Output queue: hold results while the sink stalls.
  logic [1:0]    fifo_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] fifo_cnt_q;
  logic          push, pop;

  assign push = s5_v;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {s5_mask, s5_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + CW'(push) - CW'(pop);
    end
  end

  assign out_o.valid         = (fifo_cnt_q != '0);
  assign out_o.mask_on       = fifo_q[rd_ptr_q][1];
  assign out_o.last_of_frame = fifo_q[rd_ptr_q][0];

  // Leave room for every item that may still be in the pipe.
  assign in_i.ready = (fifo_cnt_q < CW'(FIFO_DEPTH - PIPE_DEPTH));

  // Checks.
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= CW'(FIFO_DEPTH))
    else $error("output queue over its depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q < CW'(FIFO_DEPTH)) || pop)
    else $error("result pushed into a full queue");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick && tag0.last) |=> (row_q == '0) && (col_q == '0))
    else $error("counters not cleared after last item of frame");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> ((WW+1)'(col_q) <= wm1) || $past(cfg_we_i))
    else $error("column counter beyond row width");

endmodule
`default_nettype wire

FILE: tb/tb_canny_edge_stream_top.sv
// Testbench of the streaming edge detector: directed and random frames checked against a cycle-free predictor.
`default_nettype none

// Scoreboard: own copy of the line stores, counters and registers, plus the queue of
// mask items still to come out of the block.
class edge_mask_scoreboard;
  typedef struct packed {
    logic mask_on;
    logic last;
  } mask_item_t;

  logic [7:0]  raw_rows  [4][ces_pkg::MAX_WIDTH_DEF];
  logic [7:0]  blur_rows [4][ces_pkg::MAX_WIDTH_DEF];
  logic [22:0] grad_rows [4][ces_pkg::MAX_WIDTH_DEF];
  int unsigned width_reg, height_reg, thresh_reg;
  int unsigned col, row;
  int unsigned results_seen;
  int          errors;
  mask_item_t  mask_q[$];

  function new();
    width_reg    = ces_pkg::WIDTH_RST;
    height_reg   = ces_pkg::HEIGHT_RST;
    thresh_reg   = ces_pkg::THRESH_RST;
    col          = 0;
    row          = 0;
    results_seen = 0;
    errors       = 0;
  endfunction

  function int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > ces_pkg::MAX_WIDTH_DEF) return ces_pkg::MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function int unsigned eff_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function int pending();
    return mask_q.size();
  endfunction

  function void write_reg(ces_pkg::ces_reg_e idx, logic [15:0] data);
    case (idx)
      ces_pkg::REG_WIDTH:  width_reg  = data[11:0];
      ces_pkg::REG_HEIGHT: height_reg = data;
      ces_pkg::REG_THRESH: thresh_reg = data[7:0];
      default: return;
    endcase
    col = 0;
    row = 0;
  endfunction

  function int blur_px(int unsigned y, int unsigned x);
    return int'(blur_rows[y & 3][x]);
  endfunction

  function int unsigned mag_px(int unsigned y, int unsigned x);
    return grad_rows[y & 3][x][ces_pkg::MAG_BITS-1:0];
  endfunction

  function void blur_at(int unsigned y, int unsigned x, int unsigned w, int unsigned h);
    int unsigned s;
    s = 0;
    if (y != 0 && y != h - 1 && x != 0 && x != w - 1) begin
      s = raw_rows[(y-1)&3][x-1] + 2*raw_rows[(y-1)&3][x] + raw_rows[(y-1)&3][x+1]
        + 2*raw_rows[y&3][x-1] + 4*raw_rows[y&3][x] + 2*raw_rows[y&3][x+1]
        + raw_rows[(y+1)&3][x-1] + 2*raw_rows[(y+1)&3][x] + raw_rows[(y+1)&3][x+1];
      s = s >> 4;
    end
    blur_rows[y & 3][x] = s[7:0];
  endfunction

  function void grad_at(int unsigned y, int unsigned x, int unsigned w, int unsigned h);
    int gx, gy;
    int unsigned m2;
    longint ax, gyq;
    ces_pkg::ces_dir_e dir;
    grad_rows[y & 3][x] = '0;
    if (y == 0 || y == h - 1 || x == 0 || x == w - 1) return;
    gx = -blur_px(y-1, x-1) + blur_px(y-1, x+1) - 2*blur_px(y, x-1) + 2*blur_px(y, x+1)
         - blur_px(y+1, x-1) + blur_px(y+1, x+1);
    gy = -blur_px(y-1, x-1) - 2*blur_px(y-1, x) - blur_px(y-1, x+1)
         + blur_px(y+1, x-1) + 2*blur_px(y+1, x) + blur_px(y+1, x+1);
    m2 = gx*gx + gy*gy;
    // fold the lower half-plane onto the upper one
    if (gy < 0) begin
      gy = -gy;
      gx = -gx;
    end
    ax  = (gx < 0) ? -longint'(gx) : longint'(gx);
    gyq = longint'(gy) * 65536;
    if (gyq < ax * ces_pkg::TAN_LO_Q16 || (gx == 0 && gy == 0)) dir = ces_pkg::DIR_0;
    else if (gyq < ax * ces_pkg::TAN_HI_Q16) dir = (gx > 0) ? ces_pkg::DIR_45 : ces_pkg::DIR_135;
    else dir = ces_pkg::DIR_90;
    grad_rows[y & 3][x] = {dir, m2[ces_pkg::MAG_BITS-1:0]};
  endfunction

  function logic mask_at(int unsigned y, int unsigned x, int unsigned w, int unsigned h);
    int unsigned m, n1, n2;
    ces_pkg::ces_dir_e dir;
    if (y == 0 || y == h - 1 || x == 0 || x == w - 1) return 1'b0;
    m = mag_px(y, x);
    if (m < thresh_reg * thresh_reg) return 1'b0;
    dir = ces_pkg::ces_dir_e'(grad_rows[y & 3][x][22:21]);
    case (dir)
      ces_pkg::DIR_0:  begin n1 = mag_px(y, x-1);   n2 = mag_px(y, x+1);   end
      ces_pkg::DIR_45: begin n1 = mag_px(y-1, x+1); n2 = mag_px(y+1, x-1); end
      ces_pkg::DIR_90: begin n1 = mag_px(y-1, x);   n2 = mag_px(y+1, x);   end
      default:         begin n1 = mag_px(y-1, x-1); n2 = mag_px(y+1, x+1); end
    endcase
    return (m >= n1 && m >= n2);
  endfunction

  // One accepted item is one tick of the pipeline, unless it is a flush inside a frame
  // or with no frame open.
  function void note_input(logic act, logic [7:0] pix);
    int unsigned w, h, total, lag, p, q;
    mask_item_t item;
    w     = eff_width();
    h     = eff_height();
    total = w * h;
    lag   = w + 1;
    p     = row * w + col;
    if (p < total) begin
      if (act) return;
      raw_rows[row & 3][col] = pix;
    end
    if (p >= lag && p - lag < total) blur_at((p - lag) / w, (p - lag) % w, w, h);
    if (p >= 2*lag && p - 2*lag < total) grad_at((p - 2*lag) / w, (p - 2*lag) % w, w, h);
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (p >= 3*lag) begin
      q = p - 3*lag;
      if (q < total) begin
        item.mask_on = mask_at(q / w, q % w, w, h);
        item.last    = (q == total - 1);
        mask_q.push_back(item);
        if (item.last) begin
          col = 0;
          row = 0;
        end
      end
    end
  endfunction

  function void check_result(logic mask_on, logic last);
    mask_item_t exp_item;
    results_seen++;
    if (mask_q.size() == 0) begin
      $display("%0t: unexpected mask item: mask_on=%0b last=%0b", $time, mask_on, last);
      errors++;
      return;
    end
    exp_item = mask_q.pop_front();
    if (exp_item.mask_on !== mask_on) begin
      $display("%0t: mask_on expected %0b actual %0b", $time, exp_item.mask_on, mask_on);
      errors++;
    end
    if (exp_item.last !== last) begin
      $display("%0t: last_of_frame expected %0b actual %0b", $time, exp_item.last, last);
      errors++;
    end
  endfunction
endclass

module tb_canny_edge_stream_top;
  import ces_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  ces_reg_e    cfg_idx;
  logic [15:0] cfg_data;
  bit          no_gaps;
  bit          sink_held;

  ces_in_if  pix_ch ();
  ces_out_if mask_ch ();

  edge_mask_scoreboard edge_sb;

  canny_edge_stream_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pix_ch.sink),
    .out_o      (mask_ch.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Pick an idle gap: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one item and hold it until the block takes it. Entered and left just after
  // a rising edge; valid stays high for a back-to-back item.
  task automatic send_item(logic act, logic [7:0] pix);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_ch.valid  <= 1'b1;
    pix_ch.action <= act;
    pix_ch.pixel  <= pix;
    @(posedge clk_i);
    while (!pix_ch.ready) @(posedge clk_i);
    edge_sb.note_input(act, pix);
  endtask

  // Drop valid and wait until every mask item is out, then let the pipeline settle.
  task automatic drain_block();
    pix_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (edge_sb.pending() > 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  // One write per call; the enable drops for a cycle before the next write.
  task automatic write_reg(ces_reg_e idx, logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    edge_sb.write_reg(idx, data);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(logic [15:0] w, logic [15:0] h, logic [15:0] t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_THRESH, t);
  endtask

  // Raster pixel by pattern: uniform noise, black/white noise, ramp, or a vertical step.
  function automatic logic [7:0] frame_pixel(int mode, int unsigned x, int unsigned y,
                                             int unsigned w);
    case (mode)
      0: return 8'($urandom_range(0, 255));
      1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      2: return 8'(x * 37 + y * 11);
      default: return ((x > w / 2) ^ (y[0] & x[0])) ? 8'(8'hF0 + $urandom_range(0, 15))
                                                      : 8'($urandom_range(0, 15));
    endcase
  endfunction

  // Send one whole frame and its drain ticks. Noise flushes inside the frame are
  // ignored by the block; some drain ticks are pixels, which count as flushes there.
  task automatic send_frame(int unsigned w, int unsigned h, int mode, bit noisy,
                            bit pause_midway);
    int unsigned i;
    for (i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 99) < 5) send_item(1'b1, 8'($urandom_range(0, 255)));
      if (pause_midway && i == (w * h) / 2) begin
        pix_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (edge_sb.pending() > 0) @(posedge clk_i);
      end
      send_item(1'b0, frame_pixel(mode, i % w, i / w, w));
    end
    for (i = 0; i < 3 * (w + 1); i++) begin
      if ($urandom_range(0, 99) < 20) send_item(1'b0, 8'($urandom_range(0, 255)));
      else send_item(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  // Result sink: bursts of ready, short and long stalls, and one long hold-off once
  // traffic is flowing so that the output queue fills and input ready drops.
  initial begin
    int unsigned stall;
    mask_ch.ready = 1'b0;
    sink_held     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      mask_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
      if (!sink_held && edge_sb.results_seen >= 150) begin
        sink_held = 1'b1;
        stall     = 400;
      end else if ($urandom_range(0, 99) < 85) begin
        stall = $urandom_range(1, 3);
      end else begin
        stall = $urandom_range(10, 40);
      end
      mask_ch.ready <= 1'b0;
      repeat (stall - 1) @(posedge clk_i);
    end
  end

  // Check every mask item the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && mask_ch.valid && mask_ch.ready)
      edge_sb.check_result(mask_ch.mask_on, mask_ch.last_of_frame);
  end

  initial begin
    #20000000;
    $display("[canny_edge_stream_top] ERROR");
    $finish;
  end

  initial begin
    int unsigned pixels_sent, w, h, i;
    edge_sb       = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_WIDTH;
    cfg_data      = '0;
    no_gaps       = 1'b0;
    pix_ch.valid  = 1'b0;
    pix_ch.action = 1'b0;
    pix_ch.pixel  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest frame, zero threshold, extreme gray levels, a flush with no
    // frame open, a flush inside the frame and a pixel after the frame end.
    set_frame(16'd3, 16'd3, 16'd0);
    write_reg(REG_NONE, 16'hFFFF);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h55);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h7F);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h01);
    for (i = 0; i < 12; i++) send_item(i[0], 8'hAA);
    drain_block();

    // Widths and heights below range clamp to 3; wide step frame at full threshold.
    set_frame(16'd0, 16'd1, 16'd255);
    send_frame(3, 3, 1, 1'b0, 1'b0);
    drain_block();
    set_frame(16'd40, 16'd5, 16'd255);
    send_frame(40, 5, 3, 1'b0, 1'b0);
    drain_block();

    // Random frames, mostly small and well formed; count pixels and drain ticks.
    pixels_sent = 0;
    i = 0;
    while (pixels_sent < 1200) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(3, 16);
      h = $urandom_range(3, 9);
      case ($urandom_range(0, 4))
        0: set_frame(16'(w), 16'(h), 16'd0);
        1: set_frame(16'(w), 16'(h), 16'd255);
        default: set_frame(16'(w), 16'(h), 16'($urandom_range(0, 80)));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      send_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 2) == 0, i == 3);
      no_gaps = 1'b0;
      drain_block();
      pixels_sent += w * h + 3 * (w + 1);
      i++;
      // Now and then a frame cut short and then aborted by a register write.
      if ($urandom_range(0, 5) == 0) begin
        set_frame(16'(w), 16'(h), 16'($urandom_range(0, 255)));
        send_frame(0, 0, 0, 1'b0, 1'b0);
        for (int unsigned k = 0; k < w * 2 + 3; k++)
          send_item(1'b0, 8'($urandom_range(0, 255)));
        drain_block();
      end
    end

    // Tallest frame, started and then aborted.
    set_frame(16'd3, 16'hFFFF, 16'd20);
    for (i = 0; i < 120; i++) send_item(1'b0, frame_pixel(3, i % 3, i / 3, 3));
    drain_block();

    // Widest frame: the width register beyond range clamps to the full line length, so
    // a short start of it gives no mask item before the next abort.
    set_frame(16'h0FFF, 16'd3, 16'd10);
    for (i = 0; i < 100; i++) send_item(1'b0, frame_pixel(2, i, 0, MAX_WIDTH_DEF));
    drain_block();

    if (edge_sb.errors == 0) begin
      $display("[canny_edge_stream_top] OK");
    end else begin
      $display("[canny_edge_stream_top] ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: filelist.f
sv/ces_pkg.sv
sv/ces_if.sv
sv/ces_blur.sv
sv/ces_grad.sv
sv/ces_nms.sv
sv/canny_edge_stream_top.sv
tb/tb_canny_edge_stream_top.sv
